@@ src/rpd_pkg.sv @@
// ----------------------------------------------------------------------------
// rpd_pkg
// Types, codes and sizing constants shared by the range partition directory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rpd_pkg;

  localparam int MAX_PARTITIONS = 64;
  localparam int IDX_W          = $clog2(MAX_PARTITIONS);
  localparam int CNT_W          = $clog2(MAX_PARTITIONS + 1);

  localparam int ACTION_W = 2;
  localparam int POS_W    = 7;
  localparam int VID_W    = 63;
  localparam int EDGES_W  = 32;
  localparam int PIDX_W   = 6;
  localparam int PCNT_W   = 7;
  localparam int TOTAL_W  = 38;
  localparam int BOUND_W  = 64;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [BOUND_W-1:0] GMIN_RESET = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [BOUND_W-1:0] GMAX_RESET = 64'h8000_0000_0000_0000;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_MISS  = 2'd1,
    STATUS_ABOVE = 2'd2,
    STATUS_ERROR = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_INS_SHIFT,
    ST_REM_READ,
    ST_REM_SHIFT,
    ST_SEARCH,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [POS_W-1:0]    position;
    logic [VID_W-1:0]    range_low;
    logic [VID_W-1:0]    range_high;
    logic [EDGES_W-1:0]  edge_count;
    logic [VID_W-1:0]    vertex_id;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [PIDX_W-1:0]   partition_index;
    logic [PCNT_W-1:0]   partition_count;
    logic [TOTAL_W-1:0]  total_edges;
  } rsp_t;

  typedef struct packed {
    logic [VID_W-1:0]   bound;
    logic [EDGES_W-1:0] count;
  } entry_t;

endpackage

`default_nettype wire

@@ src/range_partition_directory.sv @@
// ----------------------------------------------------------------------------
// range_partition_directory
// Insert moves the entries from the top down to position up one slot, remove pulls
// the entries above position down one slot, lookup binary-searches the bounds; rejected
// requests and lookups answered by the global bounds go straight to the result.
// One transaction at a time; start is taken again in the cycle the result shows,
// and the receiver cannot stall. The entry memory moves or probes one entry per
// cycle. Reset clears count, edge total and global bounds; the memory is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module range_partition_directory (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire rpd_pkg::req_t req_i,
  output logic               result_valid_o,
  output rpd_pkg::rsp_t      result_o
);

  localparam int IDX_W   = rpd_pkg::IDX_W;
  localparam int CNT_W   = rpd_pkg::CNT_W;
  localparam int CMP_W   = rpd_pkg::CMP_W;
  localparam int BOUND_W = rpd_pkg::BOUND_W;
  localparam int TOTAL_W = rpd_pkg::TOTAL_W;

  // Entry memory, one synchronous read port and one write port
  rpd_pkg::entry_t mem [rpd_pkg::MAX_PARTITIONS];
  rpd_pkg::entry_t rdata_q;
  logic [IDX_W-1:0] mem_raddr;
  logic [IDX_W-1:0] mem_waddr;
  logic             mem_we;
  rpd_pkg::entry_t  mem_wdata;

  rpd_pkg::state_e state_q, state_d;
  rpd_pkg::req_t   req_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [BOUND_W-1:0] gmin_q, gmin_d;
  logic [BOUND_W-1:0] gmax_q, gmax_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]   lo_q, lo_d;
  logic [CNT_W-1:0]   hi_q, hi_d;
  logic [IDX_W-1:0]   mid_q, mid_d;
  rpd_pkg::status_e   status_q, status_d;
  logic [CNT_W-1:0]   pidx_q, pidx_d;
  logic               result_valid_d;
  rpd_pkg::rsp_t      result_d;

  // Decode helpers
  logic [CMP_W-1:0] pos_x, cnt_x, idx_x;
  logic [BOUND_W-1:0] vid_x, rlo_x, rhi_x;
  logic ins_ok, rem_ok, below_min, at_max, ins_put;
  logic rem_more_rd, rem_more_sh;
  logic go_left, search_more;
  logic [CNT_W-1:0] lo_nxt, hi_nxt;
  logic [CNT_W:0]   mid_sum;

  assign pos_x = CMP_W'(req_q.position);
  assign cnt_x = CMP_W'(cnt_q);
  assign idx_x = CMP_W'(idx_q);
  assign vid_x = {1'b0, req_q.vertex_id};
  assign rlo_x = {1'b0, req_q.range_low};
  assign rhi_x = {1'b0, req_q.range_high};

  assign ins_ok    = (pos_x <= cnt_x) && (cnt_q < CNT_W'(rpd_pkg::MAX_PARTITIONS));
  assign rem_ok    = pos_x < cnt_x;
  assign below_min = $signed(vid_x) < $signed(gmin_q);
  assign at_max    = !($signed(vid_x) < $signed(gmax_q));
  assign ins_put   = idx_x == pos_x;

  assign rem_more_rd = (pos_x + CMP_W'(1)) < cnt_x;
  assign rem_more_sh = (idx_x + CMP_W'(2)) < cnt_x;

  assign go_left     = req_q.vertex_id < rdata_q.bound;
  assign lo_nxt      = go_left ? lo_q : (CNT_W'(mid_q) + CNT_W'(1));
  assign hi_nxt      = go_left ? CNT_W'(mid_q) : hi_q;
  assign search_more = hi_nxt > lo_nxt;
  assign mid_sum     = {1'b0, lo_nxt} + {1'b0, hi_nxt};

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rpd_pkg::ST_IDLE: begin
        if (start) state_d = rpd_pkg::ST_EXEC;
      end
      rpd_pkg::ST_EXEC: begin
        case (req_q.action)
          rpd_pkg::ACT_INSERT: state_d = ins_ok ? rpd_pkg::ST_INS_SHIFT : rpd_pkg::ST_RESP;
          rpd_pkg::ACT_REMOVE: state_d = rem_ok ? rpd_pkg::ST_REM_READ : rpd_pkg::ST_RESP;
          rpd_pkg::ACT_LOOKUP: begin
            state_d = (below_min || at_max || cnt_q == '0) ? rpd_pkg::ST_RESP
                                                           : rpd_pkg::ST_SEARCH;
          end
          default: state_d = rpd_pkg::ST_RESP;
        endcase
      end
      rpd_pkg::ST_INS_SHIFT: begin
        if (ins_put) state_d = rpd_pkg::ST_RESP;
      end
      rpd_pkg::ST_REM_READ: begin
        state_d = rem_more_rd ? rpd_pkg::ST_REM_SHIFT : rpd_pkg::ST_RESP;
      end
      rpd_pkg::ST_REM_SHIFT: begin
        if (!rem_more_sh) state_d = rpd_pkg::ST_RESP;
      end
      rpd_pkg::ST_SEARCH: begin
        if (!search_more) state_d = rpd_pkg::ST_RESP;
      end
      rpd_pkg::ST_RESP: state_d = rpd_pkg::ST_IDLE;
      default: state_d = rpd_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    cnt_d          = cnt_q;
    total_d        = total_q;
    gmin_d         = gmin_q;
    gmax_d         = gmax_q;
    idx_d          = idx_q;
    lo_d           = lo_q;
    hi_d           = hi_q;
    mid_d          = mid_q;
    status_d       = status_q;
    pidx_d         = pidx_q;
    mem_raddr      = idx_q;
    mem_waddr      = idx_q;
    mem_we         = 1'b0;
    mem_wdata      = rdata_q;
    result_valid_d = 1'b0;
    result_d       = result_o;
    case (state_q)
      rpd_pkg::ST_IDLE: begin
        status_d = rpd_pkg::STATUS_OK;
        pidx_d   = '0;
      end
      rpd_pkg::ST_EXEC: begin
        case (req_q.action)
          rpd_pkg::ACT_INSERT: begin
            // Start at the top: fetch the last entry to move it up
            idx_d     = IDX_W'(cnt_q);
            mem_raddr = IDX_W'(cnt_q - CNT_W'(1));
            if (!ins_ok) status_d = rpd_pkg::STATUS_ERROR;
          end
          rpd_pkg::ACT_REMOVE: begin
            mem_raddr = IDX_W'(req_q.position);
            if (!rem_ok) status_d = rpd_pkg::STATUS_ERROR;
          end
          rpd_pkg::ACT_LOOKUP: begin
            lo_d      = '0;
            hi_d      = cnt_q;
            mid_d     = IDX_W'(cnt_q >> 1);
            mem_raddr = IDX_W'(cnt_q >> 1);
            if (below_min) begin
              status_d = rpd_pkg::STATUS_MISS;
            end else if (at_max) begin
              status_d = rpd_pkg::STATUS_ABOVE;
            end else if (cnt_q == '0) begin
              status_d = rpd_pkg::STATUS_MISS;
            end
          end
          default: status_d = rpd_pkg::STATUS_ERROR;
        endcase
      end
      rpd_pkg::ST_INS_SHIFT: begin
        mem_we    = 1'b1;
        mem_raddr = idx_q - IDX_W'(2);
        if (ins_put) begin
          mem_wdata.bound = req_q.range_high;
          mem_wdata.count = req_q.edge_count;
          cnt_d   = cnt_q + CNT_W'(1);
          total_d = total_q + TOTAL_W'(req_q.edge_count);
          if ($signed(rlo_x) < $signed(gmin_q)) gmin_d = rlo_x;
          if ($signed(gmax_q) < $signed(rhi_x)) gmax_d = rhi_x;
        end else begin
          idx_d = idx_q - IDX_W'(1);
        end
      end
      rpd_pkg::ST_REM_READ: begin
        total_d   = total_q - TOTAL_W'(rdata_q.count);
        idx_d     = IDX_W'(req_q.position);
        mem_raddr = IDX_W'(req_q.position) + IDX_W'(1);
        if (!rem_more_rd) cnt_d = cnt_q - CNT_W'(1);
      end
      rpd_pkg::ST_REM_SHIFT: begin
        // Pull the next entry down one slot
        mem_we    = 1'b1;
        mem_raddr = idx_q + IDX_W'(2);
        if (rem_more_sh) begin
          idx_d = idx_q + IDX_W'(1);
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      rpd_pkg::ST_SEARCH: begin
        lo_d      = lo_nxt;
        hi_d      = hi_nxt;
        mid_d     = mid_sum[IDX_W:1];
        mem_raddr = mid_sum[IDX_W:1];
        if (!search_more) begin
          if (lo_nxt < cnt_q) begin
            pidx_d = lo_nxt;
          end else begin
            status_d = rpd_pkg::STATUS_MISS;
          end
        end
      end
      rpd_pkg::ST_RESP: begin
        result_valid_d           = 1'b1;
        result_d.status          = status_q;
        result_d.partition_index = rpd_pkg::PIDX_W'(pidx_q);
        result_d.partition_count = rpd_pkg::PCNT_W'(cnt_q);
        result_d.total_edges     = total_q;
      end
      default: ;
    endcase
  end

  assign busy = state_q != rpd_pkg::ST_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= rpd_pkg::ST_IDLE;
      cnt_q          <= '0;
      total_q        <= '0;
      gmin_q         <= rpd_pkg::GMIN_RESET;
      gmax_q         <= rpd_pkg::GMAX_RESET;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      cnt_q          <= cnt_d;
      total_q        <= total_d;
      gmin_q         <= gmin_d;
      gmax_q         <= gmax_d;
      result_valid_o <= result_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == rpd_pkg::ST_IDLE && start) req_q <= req_i;
    idx_q    <= idx_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    status_q <= status_d;
    pidx_q   <= pidx_d;
    result_o <= result_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_q <= mem[mem_raddr];
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(rpd_pkg::MAX_PARTITIONS))
    else $error("entry count above table size");

  a_resp_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rpd_pkg::ST_RESP) |=> (result_valid_o && state_q == rpd_pkg::ST_IDLE))
    else $error("response not issued after RESP");

  a_strobe_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == rpd_pkg::ST_INS_SHIFT || state_q == rpd_pkg::ST_REM_SHIFT))
    else $error("memory write outside a shift");

  a_search_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rpd_pkg::ST_SEARCH) |-> (lo_q < hi_q && hi_q <= cnt_q))
    else $error("search window collapsed");
`endif

endmodule

`default_nettype wire
